>>> design/slid_pkg.sv
// Shared types and constants of the sorted list insert/delete unit.
// Used by the controller, the datapath and the top level; no dependencies.
package slid_pkg;

  // Default number of entries in the sorted store.
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new request
    logic rd;       // read the entry below (insert) or at (delete) the scan pointer
    logic step;     // compare the read entry and shift it
    logic finish;   // close the scan: final write, count and status
    logic min_rd;   // read the head entry
    logic publish;  // load the output register
  } slid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // nothing left to scan, or the insert is dropped
    logic ins_stop;   // insert has found its slot at the current entry
    logic out_free;   // output register can take a result this cycle
  } slid_sts_t;

endpackage

>>> design/slid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slid_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/slid_controller.sv
// Sequencing state machine of the sorted list insert/delete unit.
// Depends on slid_pkg for the command and status structs.
module slid_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slid_pkg::slid_sts_t sts_i,
  output slid_pkg::slid_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_CMP   = 5'b00100,
    S_MINRD = 5'b01000,
    S_MINWT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.scan_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_MINRD;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.ins_stop ? S_MINRD : S_CHECK;
      end
      S_MINRD: begin
        cmd_o.min_rd = 1'b1;
        state_d      = S_MINWT;
      end
      S_MINWT: begin
        // The head entry stays in the read register until the result leaves.
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> design/slid_datapath.sv
// Datapath of the sorted list insert/delete unit: entry store, scan pointer,
// occupancy counter and output register. Depends on slid_pkg and slid_ram.
module slid_datapath #(
  parameter int unsigned Capacity = slid_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  slid_pkg::slid_cmd_t                 cmd_i,
  output slid_pkg::slid_sts_t                 sts_o,
  input  logic                                req_type_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] value_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [slid_pkg::COUNT_W-1:0]        entry_count_o,
  output logic [1:0]                          status_o,
  output logic                                smallest_valid_o,
  output logic signed [slid_pkg::VALUE_W-1:0] smallest_value_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned VW = slid_pkg::VALUE_W;
  localparam int unsigned NW = slid_pkg::COUNT_W;

  logic                   req_q;
  logic signed [VW-1:0]   val_q;
  logic [CW-1:0]          ptr_q;
  logic [CW-1:0]          count_q;
  logic                   found_q;
  slid_pkg::status_e      status_q;

  logic                   out_valid_q;
  logic [NW-1:0]          out_count_q;
  slid_pkg::status_e      out_status_q;
  logic                   out_sv_q;
  logic signed [VW-1:0]   out_val_q;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VW-1:0]          ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VW-1:0]          ram_rdata;

  logic                   is_ins;
  logic                   full;
  logic [CW-1:0]          ptr_m1;
  logic                   ins_shift;
  logic                   del_hit;
  logic [CW+NW-1:0]       count_ext;

  assign is_ins    = (req_q == slid_pkg::REQ_INSERT);
  assign full      = (count_q == CW'(Capacity));
  assign ptr_m1    = ptr_q - 1'b1;
  assign ins_shift = ($signed(ram_rdata) > val_q);
  assign del_hit   = (ram_rdata == val_q);
  assign count_ext = {{NW{1'b0}}, count_q};

  assign sts_o.scan_done = is_ins ? (full || (ptr_q == '0)) : (ptr_q == count_q);
  assign sts_o.ins_stop  = is_ins && !ins_shift;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // An insert walks down from the top, moving larger entries up by one.
  // A delete walks up from the bottom and, past the first match, moves
  // every entry down by one.
  always_comb begin
    ram_re    = cmd_i.rd || cmd_i.min_rd;
    ram_raddr = cmd_i.min_rd ? '0 : (is_ins ? ptr_m1[AW-1:0] : ptr_q[AW-1:0]);
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = val_q;
    if (cmd_i.step) begin
      if (is_ins) begin
        ram_we    = 1'b1;
        ram_wdata = ins_shift ? ram_rdata : val_q;
      end else if (found_q) begin
        ram_we    = 1'b1;
        ram_waddr = ptr_m1[AW-1:0];
        ram_wdata = ram_rdata;
      end
    end
    if (cmd_i.finish && is_ins && !full) begin
      ram_we = 1'b1;
    end
  end

  slid_ram #(
    .Width(VW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q       <= slid_pkg::REQ_INSERT;
      ptr_q       <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        req_q   <= req_type_i;
        ptr_q   <= (req_type_i == slid_pkg::REQ_INSERT) ? count_q : '0;
        found_q <= 1'b0;
      end
      if (cmd_i.step) begin
        if (is_ins) begin
          if (ins_shift) begin
            ptr_q <= ptr_m1;
          end else begin
            count_q <= count_q + 1'b1;
          end
        end else begin
          if (!found_q && del_hit) begin
            found_q <= 1'b1;
          end
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (is_ins) begin
          if (!full) begin
            count_q <= count_q + 1'b1;
          end
        end else if (found_q) begin
          count_q <= count_q - 1'b1;
        end
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q    <= value_i;
      status_q <= slid_pkg::STATUS_OK;
    end
    if (cmd_i.finish) begin
      if (is_ins && full) begin
        status_q <= slid_pkg::STATUS_FULL;
      end else if (!is_ins && !found_q) begin
        status_q <= slid_pkg::STATUS_NOT_FOUND;
      end
    end
    if (cmd_i.publish) begin
      out_count_q  <= count_ext[NW-1:0];
      out_status_q <= status_q;
      out_sv_q     <= (count_q != '0);
      out_val_q    <= (count_q != '0) ? $signed(ram_rdata) : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entry_count_o    = out_count_q;
  assign status_o         = out_status_q;
  assign smallest_valid_o = out_sv_q;
  assign smallest_value_o = out_val_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Capacity))
    else $error("occupancy exceeds capacity");

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and written in the same cycle");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish && (status_q == slid_pkg::STATUS_FULL) |-> full)
    else $error("full status reported with room left");

  a_publish_sv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> out_valid_q && (out_sv_q == (count_q != '0)))
    else $error("smallest valid flag disagrees with occupancy");
`endif

endmodule

>>> design/sorted_list_insert_delete_unit.sv
// Top level of the sorted list insert/delete unit.
// Depends on slid_pkg, slid_controller and slid_datapath (with slid_ram).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o | req_type_i, value_i
//  out     | output    | out_valid_o/out_stall_i | entry_count_o, status_o,
//          |           |                      | smallest_valid_o, smallest_value_o
//
// One request is worked on at a time. An insert visits each entry that it moves and the
// one at which it stops (no such entry when it moves every stored entry); a delete visits
// every stored entry; a dropped insert visits none. Each entry visited is read in S_CHECK
// and compared in S_CMP, because the entry RAM has a registered read.
// Reset clears the occupancy count; the entry RAM itself is never cleared.
// A stalled output holds the result while the next request may be accepted.
module sorted_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = slid_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [slid_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [slid_pkg::COUNT_W-1:0]        entry_count_o,
  output logic [1:0]                          status_o,
  output logic                                smallest_valid_o,
  output logic signed [slid_pkg::VALUE_W-1:0] smallest_value_o
);

  slid_pkg::slid_cmd_t cmd;
  slid_pkg::slid_sts_t sts;

  slid_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  slid_datapath #(
    .Capacity(CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o),
    .smallest_valid_o(smallest_valid_o),
    .smallest_value_o(smallest_value_o)
  );

endmodule

>>> bench/tb_sorted_list_insert_delete_unit.sv
// Testbench for the sorted list insert/delete unit: directed and random insert and delete
// traffic, each result checked against a behavioral model of the sorted store.
// Depends on slid_pkg and the sorted_list_insert_delete_unit RTL.
module tb_sorted_list_insert_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import slid_pkg::*;

  localparam int unsigned MAX_CYCLES   = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 2 * CAPACITY + 20;
  localparam int unsigned RANDOM_ITEMS = 1625;
  localparam int unsigned QUIET_TAIL   = 100;
  localparam int unsigned MAX_PRINTS   = 20;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct {
    req_e   req;
    value_t value;
    bit     wait_drain;
  } request_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    status_e            status;
    logic               head_valid;
    value_t             head_value;
  } outcome_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic               req_type_i       = 1'b0;
  value_t             value_i          = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [COUNT_W-1:0] entry_count_o;
  logic [1:0]         status_o;
  logic               smallest_valid_o;
  value_t             smallest_value_o;

  request_t    pending_requests[$];
  outcome_t    expected_outcomes[$];
  value_t      sorted_store[$];
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_pct    = 10;
  int unsigned accepted    = 0;
  int unsigned checked     = 0;
  int unsigned mismatches  = 0;
  int unsigned n_insert    = 0;
  int unsigned n_delete    = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_missed    = 0;
  int unsigned peak_count  = 0;
  int unsigned cycle_count = 0;

  sorted_list_insert_delete_unit #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o),
    .smallest_valid_o(smallest_valid_o),
    .smallest_value_o(smallest_value_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Applies one request to the sorted store and returns what the unit must answer.
  function automatic outcome_t apply_request(req_e req, value_t v);
    outcome_t res;
    int       pos;
    pos = 0;
    res.status = STATUS_OK;
    if (req == REQ_INSERT) begin
      n_insert++;
      if (sorted_store.size() >= CAPACITY) begin
        res.status = STATUS_FULL;
        n_dropped++;
      end else begin
        // Equal values stay ahead of the new one.
        while (pos < sorted_store.size() && sorted_store[pos] <= v) pos++;
        sorted_store.insert(pos, v);
      end
    end else begin
      n_delete++;
      while (pos < sorted_store.size() && sorted_store[pos] != v) pos++;
      if (pos >= sorted_store.size()) begin
        res.status = STATUS_NOT_FOUND;
        n_missed++;
      end else begin
        sorted_store.delete(pos);
      end
    end
    if (sorted_store.size() > peak_count) peak_count = sorted_store.size();
    res.count      = COUNT_W'(sorted_store.size());
    res.head_valid = sorted_store.size() > 0;
    res.head_value = res.head_valid ? sorted_store[0] : '0;
    return res;
  endfunction

  task automatic push_request(req_e req, value_t v, bit wait_drain = 1'b0);
    request_t r;
    r.req        = req;
    r.value      = v;
    r.wait_drain = wait_drain;
    pending_requests.push_back(r);
  endtask

  task automatic build_directed();
    push_request(REQ_DELETE, 5);
    push_request(REQ_INSERT, 32'h7fff_ffff);
    push_request(REQ_INSERT, 32'h8000_0000);
    push_request(REQ_INSERT, 0);
    push_request(REQ_INSERT, -1);
    push_request(REQ_INSERT, 32'h8000_0000);
    push_request(REQ_DELETE, 32'h8000_0000);
    push_request(REQ_DELETE, 32'h8000_0000);
    push_request(REQ_DELETE, 12345);
    // Fill the store up to capacity, with duplicates and alternating bit patterns.
    push_request(REQ_INSERT, 32'h5555_5555);
    push_request(REQ_INSERT, 32'haaaa_aaaa);
    push_request(REQ_INSERT, 0);
    push_request(REQ_INSERT, 1);
    push_request(REQ_INSERT, -2);
    for (int i = 0; i < CAPACITY - 8; i++) push_request(REQ_INSERT, $urandom);
    push_request(REQ_INSERT, 32'h5555_5555);
    push_request(REQ_INSERT, 32'h8000_0000);
    push_request(REQ_DELETE, 32'h7fff_ffff);
  endtask

  // Mostly inserts and deletes over a small pool of values so that deletes hit and the
  // store swings between empty and full; the rest is random noise.
  task automatic build_random();
    value_t      pool[8];
    value_t      spilled[$];
    bit          filling;
    int unsigned pick;
    value_t      v;
    req_e        req;
    filling = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) begin
        filling = $urandom_range(0, 1);
        foreach (pool[j]) begin
          case ($urandom_range(0, 9))
            0:       pool[j] = 32'h8000_0000;
            1:       pool[j] = 32'h7fff_ffff;
            2:       pool[j] = 0;
            3:       pool[j] = -1;
            default: pool[j] = $urandom;
          endcase
        end
      end else if (k % 64 == 32) begin
        filling = !filling;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        req = $urandom_range(0, 1) ? REQ_DELETE : REQ_INSERT;
        v   = $urandom;
      end else begin
        req = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? REQ_INSERT : REQ_DELETE;
        if (req == REQ_INSERT) begin
          if ($urandom_range(0, 99) < 15) begin
            v = $urandom;
            spilled.push_back(v);
            if (spilled.size() > 16) void'(spilled.pop_front());
          end else begin
            v = pool[$urandom_range(0, 7)];
          end
        end else if (spilled.size() > 0 && $urandom_range(0, 99) < 30) begin
          v = spilled[$urandom_range(0, spilled.size() - 1)];
        end else begin
          v = pool[$urandom_range(0, 7)];
        end
      end
      push_request(req, v, (k % 400) == 0);
    end
  endtask

  // Driver: presents pending transactions and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    request_t item;
    bit       free;
    if (rst_ni) begin
      free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_outcomes.push_back(apply_request(req_e'(req_type_i), value_i));
        accepted++;
        if (accepted % 128 == 0) begin
          case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 5;
            2:       idle_pct = 15;
            default: idle_pct = 35;
          endcase
        end
        free = 1'b1;
      end
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].wait_drain && expected_outcomes.size() > 0)) begin
          item = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= item.req;
          value_i    <= item.value;
          if (pending_requests.size() >= QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
            send_gap = $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (count %0d, status %0d)",
                                    entry_count_o, status_o));
        end else begin
          want = expected_outcomes.pop_front();
          checked++;
          if (entry_count_o !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count_o,
                                      want.count));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %s", status_o, want.status.name()));
          if (smallest_valid_o !== want.head_valid)
            report_mismatch($sformatf("smallest_valid %b, expected %b", smallest_valid_o,
                                      want.head_valid));
          if (smallest_value_o !== want.head_value)
            report_mismatch($sformatf("smallest_value %0d, expected %0d", smallest_value_o,
                                      want.head_value));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (pending_requests.size() >= QUIET_TAIL && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_requests.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_outcomes.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
    $display("Sent %0d inserts (%0d dropped on a full store) and %0d deletes (%0d missed).",
             n_insert, n_dropped, n_delete, n_missed);
    $display("Checked %0d results; occupancy peaked at %0d of %0d entries.", checked,
             peak_count, CAPACITY);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/slid_pkg.sv
design/slid_ram.sv
design/slid_controller.sv
design/slid_datapath.sv
design/sorted_list_insert_delete_unit.sv
bench/tb_sorted_list_insert_delete_unit.sv
